@@ rtl/core/cil_pkg.sv @@
// ----------------------------------------------------------------------------
// cil_pkg
// Shared types, sizes and constants for the palette inverse lookup block.
// ----------------------------------------------------------------------------
package cil_pkg;

  localparam int ANCHOR_COUNT        = 12;
  localparam int TEMP_SPACING        = 2;
  localparam int SUBSTEPS_PER_DEGREE = 10;

  // Fine steps between two neighboring anchors.
  localparam int STEPS      = TEMP_SPACING * SUBSTEPS_PER_DEGREE;
  localparam int POINTS     = (ANCHOR_COUNT - 1) * STEPS + 1;

  localparam int ADDR_W     = $clog2(ANCHOR_COUNT);
  localparam int CNT_W      = $clog2(ANCHOR_COUNT + 1);
  localparam int K_W        = $clog2(STEPS + 1);
  localparam int IDX_W      = $clog2(POINTS);
  localparam int CH_W       = $clog2(255 * STEPS + 1);
  localparam int NUM_W      = $clog2(1023 * STEPS + 1);
  localparam int DIST_W     = $clog2(3 * 255 * STEPS + 1);

  // Floor division by STEPS as a multiply by a rounded-up reciprocal.
  localparam int RECIP_SHIFT = NUM_W + $clog2(STEPS);
  localparam int RECIP       = ((1 << RECIP_SHIFT) + STEPS - 1) / STEPS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = NUM_W + RECIP_W;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cil_cmd_e;

  typedef struct packed {
    cil_cmd_e    command;
    logic [3:0]  anchor_slot;
    logic [7:0]  anchor_red;
    logic [7:0]  anchor_green;
    logic [7:0]  anchor_blue;
    logic [9:0]  anchor_tenths;
    logic [7:0]  pixel_blue;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_red;
  } cil_in_t;

  typedef struct packed {
    logic [7:0]  match_index;
    logic [9:0]  match_tenths;
    logic [13:0] match_distance;
  } cil_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] tenths;
  } cil_anchor_t;

  // One interpolated palette point, channels and temperature scaled by STEPS.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [NUM_W-1:0] num;
  } cil_point_t;

  typedef enum logic [2:0] {
    GEN_IDLE,
    GEN_LOAD_A,
    GEN_LOAD_B,
    GEN_WALK,
    GEN_LAST
  } gen_state_e;

  typedef enum logic [1:0] {
    SRCH_SCAN,
    SRCH_SCALE,
    SRCH_SEND
  } srch_state_e;

endpackage

@@ rtl/core/colormap_inverse_lookup.sv @@
// ----------------------------------------------------------------------------
// colormap_inverse_lookup
// Inverse lookup of a thermal false-color palette.
// ----------------------------------------------------------------------------
// Input words carry a command. A load word writes one palette anchor (color
// and temperature) into the anchor memory; it gives no output word. A load
// to a slot beyond the palette is dropped. A query word
// carries a pixel color; the block walks all (ANCHOR_COUNT-1)*STEPS+1
// interpolated palette points, one per cycle from the anchor memory's single
// read port, and returns one output word with the nearest point's index, its
// temperature and the distance. After the edge that accepts a query come two
// anchor reads, the 221 points, then the minimum, temperature scaling and
// output stages. in_ready_o is low while a query is in work, so no new word
// is taken until that query's result is loaded into the output register.
// The output register lets a new word be accepted while a result waits; if
// the receiver stalls, a finished query holds its result and keeps
// in_ready_o low until the output register frees. Reset empties the output
// and returns to idle; anchor contents are undefined until loaded, and
// every anchor must be loaded before the first query.
// ----------------------------------------------------------------------------
module colormap_inverse_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cil_pkg::cil_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cil_pkg::cil_out_t out_data_o
);
  import cil_pkg::*;

  logic              busy_q;
  logic              in_fire;
  logic              query_start;
  logic              store_we;
  cil_anchor_t       wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  cil_anchor_t       rdata;
  cil_point_t        point;
  logic              done;

  assign in_ready_o  = !busy_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign query_start = in_fire && (in_data_i.command == CMD_QUERY);
  assign store_we    = in_fire && (in_data_i.command == CMD_LOAD)
                       && (CNT_W'(in_data_i.anchor_slot) < CNT_W'(ANCHOR_COUNT))
                       && ({1'b0, in_data_i.anchor_slot} < 5'(ANCHOR_COUNT));

  assign wdata.red    = in_data_i.anchor_red;
  assign wdata.green  = in_data_i.anchor_green;
  assign wdata.blue   = in_data_i.anchor_blue;
  assign wdata.tenths = in_data_i.anchor_tenths;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (query_start) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  cil_anchor_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (ADDR_W'(in_data_i.anchor_slot)),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  cil_point_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (query_start),
    .rdata_i   (rdata),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .point_o   (point)
  );

  cil_nearest_search u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (query_start),
    .pixel_blue_i  (in_data_i.pixel_blue),
    .pixel_green_i (in_data_i.pixel_green),
    .pixel_red_i   (in_data_i.pixel_red),
    .point_i       (point),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o),
    .done_o        (done)
  );

endmodule

@@ rtl/core/cil_anchor_store.sv @@
// ----------------------------------------------------------------------------
// cil_anchor_store
// Palette anchor memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cil_anchor_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [cil_pkg::ADDR_W-1:0] waddr_i,
  input  cil_pkg::cil_anchor_t      wdata_i,
  input  logic                      re_i,
  input  logic [cil_pkg::ADDR_W-1:0] raddr_i,
  output cil_pkg::cil_anchor_t      rdata_o
);
  import cil_pkg::*;

  cil_anchor_t mem [ANCHOR_COUNT];
  cil_anchor_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/cil_point_gen.sv @@
// ----------------------------------------------------------------------------
// cil_point_gen
// Walks the anchor memory and produces one interpolated palette point a cycle.
// ----------------------------------------------------------------------------
module cil_point_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  cil_pkg::cil_anchor_t       rdata_i,
  output logic                       rd_en_o,
  output logic [cil_pkg::ADDR_W-1:0] rd_addr_o,
  output cil_pkg::cil_point_t        point_o
);
  import cil_pkg::*;

  gen_state_e        state_q, state_d;
  logic [CNT_W-1:0]  rd_cnt_q;
  logic [ADDR_W-1:0] seg_q;
  logic [K_W-1:0]    k_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CH_W-1:0]   cr_q, cg_q, cb_q;
  logic [NUM_W-1:0]  num_q;
  logic signed [8:0]  dr_q, dg_q, db_q;
  logic signed [10:0] dt_q;
  cil_anchor_t       prev_q;

  logic seg_end;
  logic walk_done;
  logic more_reads;
  logic signed [8:0]  dr_new, dg_new, db_new;
  logic signed [10:0] dt_new;

  assign seg_end    = (k_q == K_W'(STEPS - 1));
  assign walk_done  = (seg_q == ADDR_W'(ANCHOR_COUNT - 2));
  assign more_reads = (rd_cnt_q < CNT_W'(ANCHOR_COUNT));

  assign dr_new = $signed({1'b0, rdata_i.red})    - $signed({1'b0, prev_q.red});
  assign dg_new = $signed({1'b0, rdata_i.green})  - $signed({1'b0, prev_q.green});
  assign db_new = $signed({1'b0, rdata_i.blue})   - $signed({1'b0, prev_q.blue});
  assign dt_new = $signed({1'b0, rdata_i.tenths}) - $signed({1'b0, prev_q.tenths});

  always_comb begin
    state_d = state_q;
    case (state_q)
      GEN_IDLE:   if (start_i) state_d = GEN_LOAD_A;
      GEN_LOAD_A: state_d = GEN_LOAD_B;
      GEN_LOAD_B: state_d = GEN_WALK;
      GEN_WALK:   if (seg_end && walk_done) state_d = GEN_LAST;
      GEN_LAST:   state_d = GEN_IDLE;
      default:    state_d = GEN_IDLE;
    endcase
  end

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = rd_cnt_q[ADDR_W-1:0];
    point_o   = '0;
    case (state_q)
      GEN_IDLE: begin
        rd_en_o   = start_i;
        rd_addr_o = '0;
      end
      GEN_LOAD_A: rd_en_o = 1'b1;
      GEN_LOAD_B: rd_en_o = more_reads;
      GEN_WALK: begin
        rd_en_o       = seg_end && !walk_done && more_reads;
        point_o.valid = 1'b1;
        point_o.first = (idx_q == '0);
      end
      GEN_LAST: begin
        point_o.valid = 1'b1;
        point_o.last  = 1'b1;
      end
      default: rd_en_o = 1'b0;
    endcase
    point_o.index = idx_q;
    point_o.red   = cr_q;
    point_o.green = cg_q;
    point_o.blue  = cb_q;
    point_o.num   = num_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= GEN_IDLE;
      rd_cnt_q <= '0;
      seg_q    <= '0;
      k_q      <= '0;
      idx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (rd_en_o) begin
        rd_cnt_q <= (state_q == GEN_IDLE) ? CNT_W'(1) : rd_cnt_q + CNT_W'(1);
      end
      case (state_q)
        GEN_LOAD_B: begin
          seg_q <= '0;
          k_q   <= '0;
          idx_q <= '0;
        end
        GEN_WALK: begin
          idx_q <= idx_q + IDX_W'(1);
          if (seg_end) begin
            k_q <= '0;
            if (!walk_done) begin
              seg_q <= seg_q + ADDR_W'(1);
            end
          end else begin
            k_q <= k_q + K_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Running interpolation: each fine step adds the anchor difference, so the
  // end of one segment lands exactly on the start of the next.
  always_ff @(posedge clk_i) begin
    case (state_q)
      GEN_LOAD_A: begin
        cr_q   <= CH_W'(rdata_i.red * STEPS);
        cg_q   <= CH_W'(rdata_i.green * STEPS);
        cb_q   <= CH_W'(rdata_i.blue * STEPS);
        num_q  <= NUM_W'(rdata_i.tenths * STEPS);
        prev_q <= rdata_i;
      end
      GEN_LOAD_B: begin
        dr_q   <= dr_new;
        dg_q   <= dg_new;
        db_q   <= db_new;
        dt_q   <= dt_new;
        prev_q <= rdata_i;
      end
      GEN_WALK: begin
        cr_q  <= cr_q + CH_W'(dr_q);
        cg_q  <= cg_q + CH_W'(dg_q);
        cb_q  <= cb_q + CH_W'(db_q);
        num_q <= num_q + NUM_W'(dt_q);
        if (seg_end && !walk_done) begin
          dr_q   <= dr_new;
          dg_q   <= dg_new;
          db_q   <= db_new;
          dt_q   <= dt_new;
          prev_q <= rdata_i;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/cil_nearest_search.sv @@
// ----------------------------------------------------------------------------
// cil_nearest_search
// Distance of each palette point to the pixel, running minimum, final scaling
// of the temperature and the output register.
// ----------------------------------------------------------------------------
module cil_nearest_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          pixel_blue_i,
  input  logic [7:0]          pixel_green_i,
  input  logic [7:0]          pixel_red_i,
  input  cil_pkg::cil_point_t point_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output cil_pkg::cil_out_t   out_data_o,
  output logic                done_o
);
  import cil_pkg::*;

  srch_state_e state_q, state_d;

  logic [CH_W-1:0]   pr_q, pg_q, pb_q;

  logic              a_valid_q, a_first_q, a_last_q;
  logic [DIST_W-1:0] a_dist_q;
  logic [IDX_W-1:0]  a_idx_q;
  logic [NUM_W-1:0]  a_num_q;

  logic [DIST_W-1:0] best_dist_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [NUM_W-1:0]  best_num_q;
  logic [PROD_W-1:0] prod_q;

  logic              out_valid_q;
  cil_out_t          out_data_q;

  logic [CH_W-1:0]   diff_r, diff_g, diff_b;
  logic [DIST_W-1:0] pt_dist;
  logic              load_out;

  assign diff_r  = (pr_q > point_i.red)   ? pr_q - point_i.red   : point_i.red - pr_q;
  assign diff_g  = (pg_q > point_i.green) ? pg_q - point_i.green : point_i.green - pg_q;
  assign diff_b  = (pb_q > point_i.blue)  ? pb_q - point_i.blue  : point_i.blue - pb_q;
  assign pt_dist = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SRCH_SCAN:  if (a_valid_q && a_last_q) state_d = SRCH_SCALE;
      SRCH_SCALE: state_d = SRCH_SEND;
      SRCH_SEND:  if (!out_valid_q || out_ready_i) state_d = SRCH_SCAN;
      default:    state_d = SRCH_SCAN;
    endcase
  end

  always_comb begin
    load_out = 1'b0;
    case (state_q)
      SRCH_SEND: load_out = !out_valid_q || out_ready_i;
      default:   load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SRCH_SCAN;
      a_valid_q   <= 1'b0;
      a_first_q   <= 1'b0;
      a_last_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      a_valid_q <= point_i.valid;
      a_first_q <= point_i.first;
      a_last_q  <= point_i.last;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pr_q <= CH_W'(pixel_red_i * STEPS);
      pg_q <= CH_W'(pixel_green_i * STEPS);
      pb_q <= CH_W'(pixel_blue_i * STEPS);
    end
    a_dist_q <= pt_dist;
    a_idx_q  <= point_i.index;
    a_num_q  <= point_i.num;
    // Strict compare keeps the lowest index on a tie.
    if (a_valid_q && (a_first_q || (a_dist_q < best_dist_q))) begin
      best_dist_q <= a_dist_q;
      best_idx_q  <= a_idx_q;
      best_num_q  <= a_num_q;
    end
    if (state_q == SRCH_SCALE) begin
      prod_q <= PROD_W'(best_num_q) * PROD_W'(RECIP);
    end
    if (load_out) begin
      out_data_q.match_index    <= 8'(best_idx_q);
      out_data_q.match_tenths   <= 10'(prod_q >> RECIP_SHIFT);
      out_data_q.match_distance <= 14'(best_dist_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign done_o      = load_out;

endmodule

@@ verif/cil_match_monitor.sv @@
// ----------------------------------------------------------------------------
// cil_match_monitor
// Watches both channels of the palette inverse lookup, keeps its own copy of
// the palette, predicts the nearest fine point for every accepted query word
// and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module cil_match_monitor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  cil_pkg::cil_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  cil_pkg::cil_out_t out_data_i,
  output int                fail_count_o,
  output int                awaited_count_o,
  output int                matched_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cil_pkg::*;

  cil_anchor_t palette [ANCHOR_COUNT];
  cil_out_t    awaited_matches [$];
  int          mismatch_total = 0;
  int          checked_total  = 0;

  function automatic int channel_gap(input int x, input int y);
    return (x > y) ? x - y : y - x;
  endfunction

  // Walks every interpolated point with channels kept scaled by STEPS, so the
  // search is exact; only the returned temperature is divided back down.
  function automatic cil_out_t nearest_point(input logic [7:0] pb, input logic [7:0] pg,
                                             input logic [7:0] pr);
    cil_anchor_t a;
    cil_anchor_t b;
    cil_out_t    res;
    int          best_dist;
    int          best_idx;
    int          best_num;
    int          idx;
    int          span;
    int          wa;
    int          d;
    best_dist = -1;
    best_idx  = 0;
    best_num  = 0;
    idx       = 0;
    for (int i = 0; i < ANCHOR_COUNT; i++) begin
      a    = palette[i];
      b    = (i + 1 < ANCHOR_COUNT) ? palette[i + 1] : a;
      span = (i + 1 < ANCHOR_COUNT) ? STEPS : 1;
      for (int k = 0; k < span; k++) begin
        wa = STEPS - k;
        d  = channel_gap(int'(pb) * STEPS, wa * int'(a.blue) + k * int'(b.blue))
           + channel_gap(int'(pg) * STEPS, wa * int'(a.green) + k * int'(b.green))
           + channel_gap(int'(pr) * STEPS, wa * int'(a.red) + k * int'(b.red));
        if (best_dist < 0 || d < best_dist) begin
          best_dist = d;
          best_idx  = idx;
          best_num  = wa * int'(a.tenths) + k * int'(b.tenths);
        end
        idx++;
      end
    end
    best_num           = best_num / STEPS;
    res.match_index    = best_idx[7:0];
    res.match_tenths   = best_num[9:0];
    res.match_distance = best_dist[13:0];
    return res;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i) begin
    cil_out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_matches.size() == 0) begin
          note_failure($sformatf("unexpected word index=%0d tenths=%0d distance=%0d",
                                 out_data_i.match_index, out_data_i.match_tenths,
                                 out_data_i.match_distance));
        end else begin
          want = awaited_matches.pop_front();
          checked_total++;
          if (out_data_i.match_index !== want.match_index ||
              out_data_i.match_tenths !== want.match_tenths ||
              out_data_i.match_distance !== want.match_distance) begin
            note_failure($sformatf({"expected index=%0d tenths=%0d distance=%0d, ",
                                    "got index=%0d tenths=%0d distance=%0d"},
                                   want.match_index, want.match_tenths,
                                   want.match_distance, out_data_i.match_index,
                                   out_data_i.match_tenths, out_data_i.match_distance));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.command == CMD_LOAD) begin
          // Loads beyond the last slot are dropped by the block.
          if (int'(in_data_i.anchor_slot) < ANCHOR_COUNT) begin
            palette[in_data_i.anchor_slot].red    = in_data_i.anchor_red;
            palette[in_data_i.anchor_slot].green  = in_data_i.anchor_green;
            palette[in_data_i.anchor_slot].blue   = in_data_i.anchor_blue;
            palette[in_data_i.anchor_slot].tenths = in_data_i.anchor_tenths;
          end
        end else begin
          awaited_matches.push_back(nearest_point(in_data_i.pixel_blue,
                                                  in_data_i.pixel_green,
                                                  in_data_i.pixel_red));
        end
      end
    end
    fail_count_o    <= mismatch_total;
    awaited_count_o <= awaited_matches.size();
    matched_count_o <= checked_total;
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives anchor loads and pixel queries into the palette inverse lookup with
// random idle gaps on both channels and one long output stall, and reports
// the verdict from the monitor's failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cil_pkg::*;

  localparam int RANDOM_ITEMS = 1350;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  cil_in_t     in_word   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cil_out_t    out_word;
  int          fail_count;
  int          awaited_count;
  int          matched_count;
  int          load_count  = 0;
  int          query_count = 0;
  int          send_quiet  = 0;
  cil_anchor_t palette_copy [ANCHOR_COUNT];

  always #10 clk = ~clk;

  colormap_inverse_lookup DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  cil_match_monitor match_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_word),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_word),
    .fail_count_o    (fail_count),
    .awaited_count_o (awaited_count),
    .matched_count_o (matched_count)
  );

  // Offers one word after a random gap and returns at the edge that takes it.
  task automatic send_word(input cil_in_t w);
    int gap;
    if (send_quiet > 0) begin
      gap = 0;
      send_quiet--;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 29) == 0) send_quiet = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_load(input int slot, input int red, input int green, input int blue,
                           input int tenths);
    cil_in_t w;
    w.command       = CMD_LOAD;
    w.anchor_slot   = slot[3:0];
    w.anchor_red    = red[7:0];
    w.anchor_green  = green[7:0];
    w.anchor_blue   = blue[7:0];
    w.anchor_tenths = tenths[9:0];
    w.pixel_blue    = 8'($urandom_range(0, 255));
    w.pixel_green   = 8'($urandom_range(0, 255));
    w.pixel_red     = 8'($urandom_range(0, 255));
    if (slot < ANCHOR_COUNT) begin
      palette_copy[slot].red    = w.anchor_red;
      palette_copy[slot].green  = w.anchor_green;
      palette_copy[slot].blue   = w.anchor_blue;
      palette_copy[slot].tenths = w.anchor_tenths;
    end
    load_count++;
    send_word(w);
  endtask

  task automatic send_query(input int blue, input int green, input int red);
    cil_in_t w;
    w.command       = CMD_QUERY;
    w.anchor_slot   = 4'($urandom_range(0, 15));
    w.anchor_red    = 8'($urandom_range(0, 255));
    w.anchor_green  = 8'($urandom_range(0, 255));
    w.anchor_blue   = 8'($urandom_range(0, 255));
    w.anchor_tenths = 10'($urandom_range(0, 1023));
    w.pixel_blue    = blue[7:0];
    w.pixel_green   = green[7:0];
    w.pixel_red     = red[7:0];
    query_count++;
    send_word(w);
  endtask

  // Rewrites every slot in order: random colors, a blue-to-red ramp, or a
  // palette with repeated neighbors that produces flat intervals and ties.
  task automatic load_palette(input int style);
    int red;
    int green;
    int blue;
    int tenths;
    for (int s = 0; s < ANCHOR_COUNT; s++) begin
      red    = $urandom_range(0, 255);
      green  = $urandom_range(0, 255);
      blue   = $urandom_range(0, 255);
      tenths = $urandom_range(0, 1023);
      if (style == 1) begin
        red    = s * 23;
        green  = $urandom_range(0, 60);
        blue   = 255 - s * 23;
        tenths = s * 93;
      end else if (style == 2 && s > 0 && $urandom_range(0, 1) == 1) begin
        red    = int'(palette_copy[s - 1].red);
        green  = int'(palette_copy[s - 1].green);
        blue   = int'(palette_copy[s - 1].blue);
        tenths = int'(palette_copy[s - 1].tenths);
      end
      send_load(s, red, green, blue, tenths);
    end
  endtask

  // A level close to an interpolated channel value given scaled by STEPS.
  function automatic int near_level(input int scaled);
    int v;
    v = scaled / STEPS + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v;
  endfunction

  initial begin : stimulus
    cil_anchor_t a;
    cil_anchor_t b;
    int          random_items;
    int          kind;
    int          slot;
    int          seg;
    int          k;
    random_items = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: a full palette with black and white ends and one flat
    // interval, loads past the last slot, then queries at color extremes, anchors and a midpoint.
    for (int s = 0; s < ANCHOR_COUNT; s++) begin
      if (s == 0) send_load(s, 0, 0, 0, 0);
      else if (s == ANCHOR_COUNT - 1) send_load(s, 255, 255, 255, 1023);
      else if (s == 4) send_load(s, int'(palette_copy[3].red), int'(palette_copy[3].green),
                                 int'(palette_copy[3].blue), int'(palette_copy[3].tenths));
      else send_load(s, s * 23, 255 - s * 23, (s * 97) % 256, s * 93);
    end
    send_load(ANCHOR_COUNT, 255, 255, 255, 1023);
    send_load(15, 255, 255, 255, 1023);
    send_query(0, 0, 0);
    send_query(255, 255, 255);
    send_query(int'(palette_copy[3].blue), int'(palette_copy[3].green),
               int'(palette_copy[3].red));
    send_query(255, 0, 255);
    send_query(0, 255, 0);
    send_query(int'(palette_copy[7].blue), int'(palette_copy[7].green),
               int'(palette_copy[7].red));
    send_query((int'(palette_copy[5].blue) + int'(palette_copy[6].blue)) / 2,
               (int'(palette_copy[5].green) + int'(palette_copy[6].green)) / 2,
               (int'(palette_copy[5].red) + int'(palette_copy[6].red)) / 2);
    // White at both ends: the tie must go to the lower index.
    send_load(0, 255, 255, 255, 1023);
    send_query(255, 255, 255);
    send_load(0, 0, 0, 0, 0);

    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        load_palette($urandom_range(0, 2));
        random_items += ANCHOR_COUNT;
      end else if (kind < 30) begin
        slot = $urandom_range(0, 15);
        send_load(slot, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255),
                  ($urandom_range(0, 9) == 0) ? 1023 * $urandom_range(0, 1)
                                              : $urandom_range(0, 1023));
        random_items++;
      end else if (kind < 65) begin
        seg = $urandom_range(0, ANCHOR_COUNT - 2);
        k   = $urandom_range(0, STEPS - 1);
        a   = palette_copy[seg];
        b   = palette_copy[seg + 1];
        send_query(near_level((STEPS - k) * int'(a.blue) + k * int'(b.blue)),
                   near_level((STEPS - k) * int'(a.green) + k * int'(b.green)),
                   near_level((STEPS - k) * int'(a.red) + k * int'(b.red)));
        random_items++;
      end else if (kind < 90) begin
        send_query($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        random_items++;
      end else begin
        send_query(255 * $urandom_range(0, 1), 255 * $urandom_range(0, 1),
                   255 * $urandom_range(0, 1));
        random_items++;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (awaited_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d anchor loads and %0d pixel queries; %0d results compared.",
             load_count, query_count, matched_count);
    $display("Both channels idled at random, with one long output stall backing up the input.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random stalls per word, quiet stretches, and one long hold-off
  // so that a finished query blocks the input.
  initial begin : sink
    int stall;
    int taken;
    int quiet;
    taken = 0;
    quiet = 0;
    forever begin
      if (taken == 150) begin
        stall = 3000;
      end else if (quiet > 0) begin
        stall = 0;
        quiet--;
      end else begin
        stall = $urandom_range(0, 19);
        if ($urandom_range(0, 29) == 0) quiet = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cil_pkg.sv
rtl/core/cil_anchor_store.sv
rtl/core/cil_point_gen.sv
rtl/core/cil_nearest_search.sv
rtl/core/colormap_inverse_lookup.sv
verif/cil_match_monitor.sv
verif/testbench.sv
